>>> design/modular_exponentiation_core_defines.svh
// Assertion macros for the modular exponentiation core.
// Expects clk_i and rst_ni in the scope of use; no other dependencies.
`ifndef MODULAR_EXPONENTIATION_CORE_DEFINES_SVH
`define MODULAR_EXPONENTIATION_CORE_DEFINES_SVH

// same-cycle implication
`define MEXP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("mexp: same-cycle check failed");

// next-cycle implication
`define MEXP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("mexp: next-cycle check failed");

`endif

>>> design/mexp_pkg.sv
// Shared constants and the modular adder for the modular exponentiation core.
// No dependencies.
package mexp_pkg;

  localparam int unsigned DataWidth = 64;
  localparam int unsigned ModWidth  = 63;
  localparam int unsigned InWidth   = 128;
  localparam int unsigned OutWidth  = 64;

  localparam logic [ModWidth-1:0] ModReset = 63'd1000000007;

  localparam logic CmdPow = 1'b0;
  localparam logic CmdInv = 1'b1;

  // (a + b) mod m for a, b < m
  function automatic logic [ModWidth-1:0] add_mod(input logic [ModWidth-1:0] a,
                                                  input logic [ModWidth-1:0] b,
                                                  input logic [ModWidth-1:0] m);
    logic [ModWidth:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) begin
        s = s - {1'b0, m};
      end
      add_mod = s[ModWidth-1:0];
    end
  endfunction

endpackage

>>> design/modular_exponentiation_core.sv
// Modular exponentiation core: operand reduction and square-and-multiply.
// Depends on mexp_pkg and modular_exponentiation_core_defines.svh.
//
//   port group   dir  contents
//   s_axis_*     in   operand, exponent (tdata), command (tuser)
//   m_axis_*     out  residue (tdata)
//   cfg_*        in   modulus write
//
// One word at a time: ready only while idle. Reduction is a restoring
// remainder over the 64 operand bits; then each exponent bit goes through a
// check, a multiply on set bits and a squaring, and a product takes one
// shift-add step per multiplier bit up to its top set bit, plus a final step. A
// finished word sits in the output register while the next word is taken, and
// a stalled output holds the core in its final state. Reset: modulus 1000000007.
`include "modular_exponentiation_core_defines.svh"

module modular_exponentiation_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [63:0] operand_value, [126:64] power_exponent, [127] zero
  input  logic [mexp_pkg::InWidth-1:0]     s_axis_tdata,
  // [0] command
  input  logic [0:0]                       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [62:0] residue_out, [63] zero
  output logic [mexp_pkg::OutWidth-1:0]    m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [mexp_pkg::ModWidth-1:0]    cfg_wdata_i
);

  localparam int unsigned MW = mexp_pkg::ModWidth;
  localparam int unsigned DW = mexp_pkg::DataWidth;

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StRed  = 3'd1;
  localparam logic [2:0] StFix  = 3'd2;
  localparam logic [2:0] StChk  = 3'd3;
  localparam logic [2:0] StMul  = 3'd4;
  localparam logic [2:0] StSqr  = 3'd5;
  localparam logic [2:0] StFin  = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [MW-1:0] mod_q;
  logic [5:0]    cnt_q, cnt_d;
  logic [DW-1:0] dvd_q, dvd_d;
  logic [MW-1:0] rem_q, rem_d;
  logic          neg_q, neg_d;
  logic [MW-1:0] base_q, base_d;
  logic [MW-1:0] res_q, res_d;
  logic [MW-1:0] exp_q, exp_d;
  logic [MW-1:0] acc_q, acc_d;
  logic [MW-1:0] ma_q, ma_d;
  logic [MW-1:0] mb_q, mb_d;
  logic [MW-1:0] out_q, out_d;
  logic          ovld_q, ovld_d;

  logic          in_acc;
  logic [DW-1:0] op_in;
  logic [MW-1:0] exp_in;
  logic [DW-1:0] rem_sh;
  logic [DW-1:0] rem_sub;
  logic [MW-1:0] acc_add;
  logic [MW-1:0] ma_dbl;

  assign s_axis_tready = (state_q == StIdle);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign op_in         = s_axis_tdata[DW-1:0];
  assign exp_in        = s_axis_tdata[DW+MW-1:DW];

  // shared datapath: one restoring-remainder step, one shift-add multiply step
  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign rem_sub = (rem_sh >= {1'b0, mod_q}) ? rem_sh - {1'b0, mod_q} : rem_sh;
  assign acc_add = mexp_pkg::add_mod(acc_q, ma_q, mod_q);
  assign ma_dbl  = mexp_pkg::add_mod(ma_q, ma_q, mod_q);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    dvd_d   = dvd_q;
    rem_d   = rem_q;
    neg_d   = neg_q;
    base_d  = base_q;
    res_d   = res_q;
    exp_d   = exp_q;
    acc_d   = acc_q;
    ma_d    = ma_q;
    mb_d    = mb_q;
    out_d   = out_q;
    ovld_d  = ovld_q;

    if (ovld_q && m_axis_tready) begin
      ovld_d = 1'b0;
    end

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          neg_d = op_in[DW-1];
          dvd_d = op_in[DW-1] ? (~op_in + {{(DW-1){1'b0}}, 1'b1}) : op_in;
          rem_d = '0;
          cnt_d = '1;
          exp_d = (s_axis_tuser[0] == mexp_pkg::CmdInv)
                  ? mod_q - {{(MW-2){1'b0}}, 2'd2} : exp_in;
          if (mod_q < {{(MW-2){1'b0}}, 2'd2}) begin
            res_d   = '0;
            state_d = StFin;
          end else begin
            res_d   = {{(MW-1){1'b0}}, 1'b1};
            state_d = StRed;
          end
        end
      end
      StRed: begin
        rem_d = rem_sub[MW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
        cnt_d = cnt_q - 6'd1;
        if (cnt_q == '0) begin
          state_d = StFix;
        end
      end
      StFix: begin
        // negative operand maps upward unless it divides evenly
        base_d  = (neg_q && (rem_q != '0)) ? mod_q - rem_q : rem_q;
        state_d = StChk;
      end
      StChk: begin
        acc_d = '0;
        mb_d  = base_q;
        if (exp_q == '0) begin
          state_d = StFin;
        end else if (exp_q[0]) begin
          ma_d    = res_q;
          state_d = StMul;
        end else begin
          ma_d    = base_q;
          state_d = StSqr;
        end
      end
      StMul: begin
        if (mb_q == '0) begin
          res_d   = acc_q;
          acc_d   = '0;
          ma_d    = base_q;
          mb_d    = base_q;
          state_d = StSqr;
        end else begin
          acc_d = mb_q[0] ? acc_add : acc_q;
          ma_d  = ma_dbl;
          mb_d  = {1'b0, mb_q[MW-1:1]};
        end
      end
      StSqr: begin
        if (mb_q == '0) begin
          base_d  = acc_q;
          exp_d   = {1'b0, exp_q[MW-1:1]};
          state_d = StChk;
        end else begin
          acc_d = mb_q[0] ? acc_add : acc_q;
          ma_d  = ma_dbl;
          mb_d  = {1'b0, mb_q[MW-1:1]};
        end
      end
      StFin: begin
        if (!ovld_q || m_axis_tready) begin
          out_d   = res_q;
          ovld_d  = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ovld_q  <= 1'b0;
      mod_q   <= mexp_pkg::ModReset;
    end else begin
      state_q <= state_d;
      ovld_q  <= ovld_d;
      if (cfg_we_i) begin
        mod_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    neg_q  <= neg_d;
    base_q <= base_d;
    res_q  <= res_d;
    exp_q  <= exp_d;
    acc_q  <= acc_d;
    ma_q   <= ma_d;
    mb_q   <= mb_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {1'b0, out_q};

  `MEXP_ASSERT_NEXT(a_busy_after_accept, in_acc, !s_axis_tready)
  `MEXP_ASSERT_NOW(a_out_in_range, m_axis_tvalid, (out_q < mod_q) || (out_q == '0))
  `MEXP_ASSERT_NOW(a_rem_in_range, state_q == StRed, rem_q < mod_q)
  `MEXP_ASSERT_NOW(a_mul_in_range, (state_q == StMul) || (state_q == StSqr),
                   (acc_q < mod_q) && (ma_q < mod_q))

endmodule
